@@ sv/idq_pkg.sv @@
package idq_pkg;

    localparam int WORD_W = 64;
    localparam int DATA_W = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DATA_W-1:0] data_t;

    // Payload of one divide step: partial remainder, divisor, sign and zero flags, and dividend bits that
    // shift out at the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic  zero;
        logic  neg_q;
        logic  neg_r;
        data_t rem;
        data_t num;
        data_t div;
    } step_t;

endpackage

@@ sv/idq_step.sv @@
module idq_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  idq_pkg::step_t in_data,
    output logic           out_valid,
    output idq_pkg::step_t out_data
);

    logic                      valid_reg;
    idq_pkg::step_t            data_reg;
    idq_pkg::step_t            data_next;
    logic [idq_pkg::DATA_W-1:0] shifted;
    logic [idq_pkg::DATA_W:0]   diff;
    logic                      take;

    always_comb begin
        shifted   = {in_data.rem[idq_pkg::DATA_W-2:0], in_data.num[idq_pkg::DATA_W-1]};
        diff      = {1'b0, shifted} - {1'b0, in_data.div};
        // Subtract when the bit shifted out of the remainder was set or no borrow.
        take      = in_data.rem[idq_pkg::DATA_W-1] | ~diff[idq_pkg::DATA_W];
        data_next = in_data;
        data_next.rem = take ? diff[idq_pkg::DATA_W-1:0] : shifted;
        data_next.num = {in_data.num[idq_pkg::DATA_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/int64_divide_quotient_remainder.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Stages: operand stage, 64 divide steps, sign-fix stage.
// Throughput: one word per cycle; a stall on m_ready freezes every stage at once.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is not reset.
module int64_divide_quotient_remainder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [idq_pkg::WORD_W-1:0] s_dividend,
    input  logic [idq_pkg::WORD_W-1:0] s_divisor,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [idq_pkg::WORD_W-1:0] m_quotient,
    output logic [idq_pkg::WORD_W-1:0] m_remainder,
    output logic                       m_div_by_zero
);

    localparam int DW = idq_pkg::DATA_W;

    logic           adv;
    logic           v [0:DW];
    idq_pkg::step_t p [0:DW];
    logic [DW:0]    vbits;

    logic           in_valid_reg;
    idq_pkg::step_t in_data_reg;
    idq_pkg::step_t in_data_next;
    idq_pkg::data_t a;
    idq_pkg::data_t b;
    logic           neg_a;
    logic           neg_b;

    logic           m_valid_reg;
    idq_pkg::word_t m_quotient_reg;
    idq_pkg::word_t m_quotient_next;
    idq_pkg::word_t m_remainder_reg;
    idq_pkg::word_t m_remainder_next;
    logic           m_div_by_zero_reg;

    // Advance the whole pipeline unless a finished word is held at the output.
    assign adv     = ~m_valid_reg | m_ready;
    assign s_ready = adv;

    always_comb begin
        a     = s_dividend[DW-1:0];
        b     = s_divisor[DW-1:0];
        neg_a = s_action & a[DW-1];
        neg_b = s_action & b[DW-1];
        in_data_next.zero  = (b == '0);
        in_data_next.neg_q = neg_a ^ neg_b;
        in_data_next.neg_r = neg_a;
        in_data_next.rem   = '0;
        in_data_next.num   = neg_a ? (-a) : a;
        in_data_next.div   = neg_b ? (-b) : b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_data_reg <= in_data_next;
        end
    end

    assign v[0] = in_valid_reg;
    assign p[0] = in_data_reg;

    for (genvar i = 0; i < DW; i++) begin : g_step
        idq_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v[i]),
            .in_data   (p[i]),
            .out_valid (v[i+1]),
            .out_data  (p[i+1])
        );
    end

    for (genvar i = 0; i <= DW; i++) begin : g_vbits
        assign vbits[i] = v[i];
    end

    always_comb begin
        if (p[DW].zero) begin
            m_quotient_next  = '0;
            m_remainder_next = '0;
        end else begin
            m_quotient_next  = idq_pkg::word_t'(p[DW].neg_q ? (-p[DW].num) : p[DW].num);
            m_remainder_next = idq_pkg::word_t'(p[DW].neg_r ? (-p[DW].rem) : p[DW].rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_quotient_reg    <= m_quotient_next;
            m_remainder_reg   <= m_remainder_next;
            m_div_by_zero_reg <= p[DW].zero;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_quotient    = m_quotient_reg;
    assign m_remainder   = m_remainder_reg;
    assign m_div_by_zero = m_div_by_zero_reg;

`ifndef NO_ASSERTIONS
    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vbits))
        else $error("pipeline valid bits moved during a stall");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (v[DW] && !p[DW].zero) |-> (p[DW].rem < p[DW].div))
        else $error("final partial remainder not below divisor");

    a_zero_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_div_by_zero_reg) |-> (m_quotient_reg == '0 && m_remainder_reg == '0))
        else $error("divide by zero gave nonzero results");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && vbits == '0))
        else $error("valid bits survived reset");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam logic           MODE_UNSIGNED = 1'b0;
    localparam logic           MODE_SIGNED   = 1'b1;
    localparam idq_pkg::word_t WORD_ONES     = {idq_pkg::WORD_W{1'b1}};
    localparam idq_pkg::word_t WORD_MIN      = idq_pkg::word_t'(1) << (idq_pkg::WORD_W - 1);
    localparam idq_pkg::word_t WORD_MAXPOS   = WORD_ONES >> 1;
    localparam int             RANDOM_JOBS   = 1300;
    localparam int             MAX_IDLE      = 13;
    localparam int             SETTLE_CYCLES = 100;

    typedef struct packed {
        idq_pkg::word_t quotient;
        idq_pkg::word_t remainder;
        logic           zero;
    } div_result_t;

    typedef struct {
        logic           mode;
        idq_pkg::word_t dividend;
        idq_pkg::word_t divisor;
        int             gap;
        bit             drain;
    } div_job_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    logic           s_action = 1'b0;
    idq_pkg::word_t s_dividend = '0;
    idq_pkg::word_t s_divisor = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    idq_pkg::word_t m_quotient;
    idq_pkg::word_t m_remainder;
    logic           m_div_by_zero;

    div_job_t    job_queue[$];
    div_result_t expected_results[$];
    int          loaded_count = 0;
    int          checked_count = 0;
    int          errors = 0;
    int          gap_left = 0;
    bit          gap_armed = 1'b0;
    int          stall_left = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    int64_divide_quotient_remainder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_dividend    (s_dividend),
        .s_divisor     (s_divisor),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quotient    (m_quotient),
        .m_remainder   (m_remainder),
        .m_div_by_zero (m_div_by_zero)
    );

    always #4 aclk = ~aclk;

    function automatic div_result_t predict_division(logic mode, idq_pkg::word_t num,
                                                     idq_pkg::word_t den);
        div_result_t    res;
        idq_pkg::word_t mask;
        idq_pkg::word_t a;
        idq_pkg::word_t b;
        idq_pkg::word_t mag_a;
        idq_pkg::word_t mag_b;
        logic           neg_a;
        logic           neg_b;
        mask = WORD_ONES >> (idq_pkg::WORD_W - idq_pkg::DATA_W);
        a = num & mask;
        b = den & mask;
        res = '0;
        if (b == '0) begin
            res.zero = 1'b1;
        end else begin
            neg_a = (mode == MODE_SIGNED) && a[idq_pkg::DATA_W-1];
            neg_b = (mode == MODE_SIGNED) && b[idq_pkg::DATA_W-1];
            mag_a = neg_a ? ((-a) & mask) : a;
            mag_b = neg_b ? ((-b) & mask) : b;
            res.quotient = mag_a / mag_b;
            res.remainder = mag_a % mag_b;
            // truncate toward zero; remainder follows the dividend's sign
            if (neg_a != neg_b)
                res.quotient = (-res.quotient) & mask;
            if (neg_a)
                res.remainder = (-res.remainder) & mask;
        end
        return res;
    endfunction

    function automatic idq_pkg::word_t pick_operand();
        idq_pkg::word_t v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = idq_pkg::word_t'($urandom_range(0, 15));
            1: v = idq_pkg::word_t'(1) << $urandom_range(0, idq_pkg::WORD_W - 1);
            2: v = WORD_MIN + idq_pkg::word_t'($urandom_range(0, 3));
            3: v = WORD_ONES - idq_pkg::word_t'($urandom_range(0, 3));
            4: v = WORD_MAXPOS - idq_pkg::word_t'($urandom_range(0, 3));
            5, 6: begin
                v = v >> $urandom_range(1, idq_pkg::WORD_W - 1);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic int draw_idle(ref bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic void add_job(logic mode, idq_pkg::word_t a, idq_pkg::word_t b,
                                    bit drain);
        div_job_t job;
        job.mode = mode;
        job.dividend = a;
        job.divisor = b;
        job.gap = draw_idle(tx_calm);
        job.drain = drain;
        job_queue.push_back(job);
    endfunction

    function automatic void report_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // driver: present the next word once the previous one is taken and its gap is over
    always @(posedge aclk) begin
        div_job_t job;
        logic     load;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            load = 1'b0;
            if (job_queue.size() > 0) begin
                if (!gap_armed) begin
                    gap_left = job_queue[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!job_queue[0].drain || checked_count == loaded_count) begin
                    job = job_queue.pop_front();
                    gap_armed = 1'b0;
                    load = 1'b1;
                end
            end
            s_valid <= load;
            if (load) begin
                s_action <= job.mode;
                s_dividend <= job.dividend;
                s_divisor <= job.divisor;
                // the presented word is held until taken, so it is safe to queue now
                expected_results.push_back(predict_division(job.mode, job.dividend,
                                                             job.divisor));
                loaded_count <= loaded_count + 1;
            end
        end
    end

    // monitor: check each taken result, then stall ready for a random while
    always @(posedge aclk) begin
        div_result_t want;
        logic        ready_next;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            ready_next = m_ready;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result q=%h r=%h z=%b",
                                           m_quotient, m_remainder, m_div_by_zero));
                end else begin
                    want = expected_results.pop_front();
                    checked_count <= checked_count + 1;
                    if (m_quotient !== want.quotient || m_remainder !== want.remainder ||
                        m_div_by_zero !== want.zero)
                        report_error($sformatf(
                            "expected q=%h r=%h z=%b, got q=%h r=%h z=%b",
                            want.quotient, want.remainder, want.zero,
                            m_quotient, m_remainder, m_div_by_zero));
                end
                stall_left = draw_idle(rx_calm);
                ready_next = (stall_left == 0);
            end else if (!m_ready) begin
                if (stall_left > 1) begin
                    stall_left--;
                end else begin
                    stall_left = 0;
                    ready_next = 1'b1;
                end
            end
            m_ready <= ready_next;
        end
    end

    initial begin
        add_job(MODE_UNSIGNED, 64'd0, 64'd0, 1'b0);
        add_job(MODE_SIGNED, WORD_ONES, 64'd0, 1'b0);
        add_job(MODE_UNSIGNED, WORD_ONES, 64'd1, 1'b0);
        add_job(MODE_UNSIGNED, WORD_ONES, WORD_ONES, 1'b0);
        add_job(MODE_UNSIGNED, 64'd0, WORD_ONES, 1'b0);
        add_job(MODE_UNSIGNED, 64'd1, WORD_ONES, 1'b0);
        add_job(MODE_UNSIGNED, WORD_ONES, WORD_MIN, 1'b0);
        add_job(MODE_UNSIGNED, WORD_MIN, WORD_ONES, 1'b0);
        add_job(MODE_UNSIGNED, 64'd100, 64'd7, 1'b0);
        // most negative over minus one wraps
        add_job(MODE_SIGNED, WORD_MIN, WORD_ONES, 1'b0);
        add_job(MODE_SIGNED, WORD_MIN, 64'd1, 1'b0);
        add_job(MODE_SIGNED, WORD_MIN, WORD_MIN, 1'b0);
        add_job(MODE_SIGNED, WORD_ONES, WORD_MIN, 1'b0);
        add_job(MODE_SIGNED, WORD_MIN, 64'd2, 1'b0);
        add_job(MODE_SIGNED, WORD_MAXPOS, WORD_ONES, 1'b0);
        add_job(MODE_SIGNED, WORD_MAXPOS, WORD_MIN, 1'b0);
        add_job(MODE_SIGNED, WORD_ONES, WORD_ONES, 1'b0);
        add_job(MODE_SIGNED, 64'd7, -64'd2, 1'b0);
        add_job(MODE_SIGNED, -64'd7, 64'd2, 1'b0);
        add_job(MODE_SIGNED, -64'd7, -64'd2, 1'b0);
        add_job(MODE_SIGNED, 64'd7, 64'd2, 1'b0);
        add_job(MODE_SIGNED, 64'd0, WORD_MIN, 1'b0);
        // first random word waits for the pipe to empty
        for (int i = 0; i < RANDOM_JOBS; i++)
            add_job(logic'($urandom_range(0, 1)), pick_operand(), pick_operand(),
                    i == 0 || $urandom_range(0, 199) == 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (job_queue.size() > 0 || s_valid)
            @(posedge aclk);
        while (checked_count != loaded_count)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/idq_pkg.sv
sv/idq_step.sv
sv/int64_divide_quotient_remainder.sv
tb/sv/testbench.sv
